[sv/psfc_pkg.sv]
// shared types, format codes and register addresses for the pcm sample format converter
package psfc_pkg;

   typedef enum logic [2:0] {
      FMT_S8  = 3'd0,
      FMT_U8  = 3'd1,
      FMT_S16 = 3'd2,
      FMT_U16 = 3'd3,
      FMT_S24 = 3'd4,
      FMT_F32 = 3'd5
   } fmt_type;

   localparam logic [1:0] REG_SRC_FMT  = 2'd0;
   localparam logic [1:0] REG_SRC_SWAP = 2'd1;
   localparam logic [1:0] REG_DST_FMT  = 2'd2;
   localparam logic [1:0] REG_DST_SWAP = 2'd3;

   typedef struct packed {
      logic [2:0] sf;
      logic [2:0] df;
      logic       ds;
      logic       bad;
   } ctl_type;

endpackage

[sv/pcm_sample_format_converter.sv]
// pcm sample format converter: s8, u8, s16, u16, s24 and float32 sample re-encoding
//
// usage:
//   program the format registers over the apb port (byte address 4*i),
//   only while no beat is in flight. source and destination are sampled per beat.
//   input beats arrive on req_valid / req_sample_in, accepted when req_valid
//   is high and req_stall is low. results leave on rsp_valid with
//   rsp_sample_out and rsp_unsupported, taken when rsp_stall is low.
// pipeline and throughput:
//   four register stages: unpack, scale, round and clamp, pack. one beat is
//   taken every cycle while the output is not stalled.
// stall:
//   the whole pipeline holds while rsp_stall is high and the output stage is
//   full; bubbles inside the pipeline are squeezed out so nothing is lost.
// reset:
//   synchronous, active high. clears all valid bits and loads the format
//   registers with float32 source, native s16 destination, no swap.
module pcm_sample_format_converter
   import psfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sample_out,
   output logic        rsp_unsupported,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // configuration registers
   logic [2:0] src_fmt_ff, dst_fmt_ff;
   logic       src_swap_ff, dst_swap_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff  <= FMT_F32;
         src_swap_ff <= 1'b0;
         dst_fmt_ff  <= FMT_S16;
         dst_swap_ff <= 1'b0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_SRC_FMT:  src_fmt_ff  <= pwdata[2:0];
            REG_SRC_SWAP: src_swap_ff <= pwdata[0];
            REG_DST_FMT:  dst_fmt_ff  <= pwdata[2:0];
            REG_DST_SWAP: dst_swap_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[1:0] == 2'b00) begin
         case (reg_idx)
            REG_SRC_FMT:  prdata = {29'd0, src_fmt_ff};
            REG_SRC_SWAP: prdata = {31'd0, src_swap_ff};
            REG_DST_FMT:  prdata = {29'd0, dst_fmt_ff};
            REG_DST_SWAP: prdata = {31'd0, dst_swap_ff};
            default:      prdata = 32'd0;
         endcase
      end
   end

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4       = !v4_ff || !rsp_stall;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // stage 1: pair check and unpack
   logic    ss, ds, ok;
   logic [31:0] n_in;
   ctl_type c1_in, c1_ff, c2_ff, c3_ff;
   logic [31:0] n1_ff, n2_ff, n3_ff;

   assign ss = (src_fmt_ff >= FMT_S16 && src_fmt_ff <= FMT_S24) ? src_swap_ff : 1'b0;
   assign ds = (dst_fmt_ff >= FMT_S16 && dst_fmt_ff <= FMT_S24) ? dst_swap_ff : 1'b0;

   always_comb begin
      ok = 1'b0;
      case (src_fmt_ff)
         FMT_F32: ok = dst_fmt_ff <= FMT_S24;
         FMT_S24: ok = dst_fmt_ff == FMT_F32 || dst_fmt_ff == FMT_S16
                       || (dst_fmt_ff == FMT_S24 && ss != ds);
         FMT_S16: ok = dst_fmt_ff == FMT_F32 || dst_fmt_ff == FMT_S24
                       || dst_fmt_ff == FMT_S8 || dst_fmt_ff == FMT_U8
                       || (dst_fmt_ff == FMT_S16 && ss != ds)
                       || (dst_fmt_ff == FMT_U16 && !ds);
         FMT_U16: ok = dst_fmt_ff == FMT_F32 || dst_fmt_ff == FMT_S8
                       || dst_fmt_ff == FMT_U8
                       || (dst_fmt_ff == FMT_U16 && ss != ds)
                       || (dst_fmt_ff == FMT_S16 && !ds);
         FMT_S8:  ok = dst_fmt_ff == FMT_F32 || dst_fmt_ff == FMT_S16
                       || dst_fmt_ff == FMT_U16 || dst_fmt_ff == FMT_U8;
         FMT_U8:  ok = dst_fmt_ff == FMT_F32 || dst_fmt_ff == FMT_S16
                       || dst_fmt_ff == FMT_U16 || dst_fmt_ff == FMT_S8;
         default: ok = 1'b0;
      endcase
   end

   always_comb begin
      case (src_fmt_ff)
         FMT_S8, FMT_U8: n_in = {24'd0, req_sample_in[7:0]};
         FMT_S24: n_in = ss ? {8'd0, req_sample_in[7:0], req_sample_in[15:8],
                               req_sample_in[23:16]}
                            : {8'd0, req_sample_in[23:0]};
         FMT_F32: n_in = req_sample_in;
         default: n_in = ss ? {16'd0, req_sample_in[7:0], req_sample_in[15:8]}
                            : {16'd0, req_sample_in[15:0]};
      endcase
      c1_in.sf  = src_fmt_ff;
      c1_in.df  = dst_fmt_ff;
      c1_in.ds  = ds;
      c1_in.bad = !ok;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         n1_ff <= n_in;
         c1_ff <= c1_in;
      end
   end

   // stage 2: float decode to fixed point, or integer to signed value
   // fixed point: fx = value * 2^23 truncated toward zero, 24 bit magnitude;
   // half tracks bits below 2^-23 relative to full scale (for s16 and u16 rounding)
   logic [7:0]  e1;
   logic [23:0] m1;
   logic        is_nan, s1;
   logic        ge_one, lt_mone;
   logic [7:0]  sh;
   logic [47:0] wide;
   logic [23:0] mag_in;
   logic        stk_in;
   logic [31:0] iv_in;
   logic        sgn2_ff, ge2_ff, lt2_ff, stk2_ff;
   logic [23:0] mag2_ff;
   logic [31:0] iv2_ff;
   logic [15:0] half_in, half2_ff;

   assign e1      = n1_ff[30:23];
   assign is_nan  = (e1 == 8'hff) && (n1_ff[22:0] != 23'd0);
   assign s1      = n1_ff[31] & !is_nan;
   assign m1      = (e1 == 8'd0) ? {1'b0, n1_ff[22:0]} : {1'b1, n1_ff[22:0]};
   assign ge_one  = !is_nan && !n1_ff[31] && (e1 >= 8'd127);
   assign lt_mone = !is_nan && n1_ff[31] && (e1 > 8'd127 || (e1 == 8'd127 && n1_ff[22:0] != 0));

   // value*2^23 = m * 2^(e-127-23+23) = m >> (127-e); e=0 is denormal (scale as e=1)
   always_comb begin
      if (e1 >= 8'd127)      sh = 8'd0;
      else if (e1 == 8'd0)   sh = 8'd126;
      else                   sh = 8'd127 - e1;
      if (sh > 8'd47) begin
         wide = 48'd0;
         stk_in = (m1 != 24'd0);
      end else begin
         wide = {m1, 24'd0} >> sh[5:0];
         stk_in = 1'b0;
      end
      mag_in  = wide[47:24];
      half_in = wide[23:8];
      if (sh <= 8'd47) stk_in = (wide[7:0] != 8'd0) || (({m1, 24'd0} << (6'd48 - sh[5:0]))
                                != 48'd0 && sh > 8'd24);
      if (is_nan) begin
         mag_in = 24'd0;
         half_in = 16'd0;
         stk_in = 1'b0;
      end
      case (c1_ff.sf)
         FMT_S24: iv_in = {{8{n1_ff[23]}}, n1_ff[23:0]};
         FMT_S16: iv_in = {{16{n1_ff[15]}}, n1_ff[15:0]};
         FMT_U16: iv_in = {16'd0, n1_ff[15:0]} - 32'd32768;
         FMT_S8:  iv_in = {{24{n1_ff[7]}}, n1_ff[7:0]};
         default: iv_in = {24'd0, n1_ff[7:0]} - 32'd128;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         c2_ff    <= c1_ff;
         sgn2_ff  <= s1 && (mag_in != 24'd0 || half_in != 16'd0 || stk_in);
         ge2_ff   <= ge_one;
         lt2_ff   <= lt_mone;
         mag2_ff  <= mag_in;
         half2_ff <= half_in;
         stk2_ff  <= stk_in;
         iv2_ff   <= iv_in;
      end
   end

   // stage 3: float to integer targets, integer to float encode
   logic [23:0] s24_r;
   logic [15:0] s16_r, u16_r;
   logic [31:0] flt_r, res3_in, res3_ff;
   logic [15:0] q16;
   logic        rb, st, rup;
   logic [16:0] m16;
   logic [31:0] av;
   logic [4:0]  lz;
   logic [31:0] nrm;
   logic [7:0]  ex_base;
   logic        u16_up, u16_nz, u16_near, u16_dn;

   always_comb begin
      // s24 truncates toward zero
      if (ge2_ff)       s24_r = 24'h7fffff;
      else if (lt2_ff)  s24_r = 24'h800000;
      else if (sgn2_ff) s24_r = 24'd0 - mag2_ff;
      else              s24_r = mag2_ff;
      // s16 rounds half to even on magnitude (float add is symmetric)
      q16 = mag2_ff[23:8];
      rb  = mag2_ff[7];
      st  = (mag2_ff[6:0] != 7'd0) || half2_ff != 16'd0 || stk2_ff;
      rup = rb && (st || q16[0]);
      m16 = {1'b0, q16} + {16'd0, rup};
      if (ge2_ff || (!sgn2_ff && m16 > 17'd32767)) s16_r = 16'h7fff;
      else if (lt2_ff || (sgn2_ff && m16 > 17'd32768)) s16_r = 16'h8000;
      else if (sgn2_ff) s16_r = 16'd0 - m16[15:0];
      else s16_r = m16[15:0];
      // u16: 32768 + f*32768 rounded to float32, then truncated
      // positive sum has a 2^-8 grid, so a fraction of 511/512 or more carries
      u16_up   = (mag2_ff[7:0] == 8'hff) && half2_ff[15];
      // negative sum below 32768 has a 2^-9 grid, so a fraction up to 2^-10 rounds back
      u16_nz   = (mag2_ff[7:0] != 8'd0) || half2_ff != 16'd0 || stk2_ff;
      u16_near = (mag2_ff[7:0] == 8'd0) && !half2_ff[15]
                 && !(half2_ff[14] && (half2_ff[13:0] != 14'd0 || stk2_ff));
      u16_dn   = u16_nz && !u16_near;
      if (ge2_ff) u16_r = 16'hffff;
      else if (lt2_ff) u16_r = 16'd0;
      else if (sgn2_ff) begin
         if (mag2_ff[23]) u16_r = 16'd0;
         else u16_r = 16'd32768 - mag2_ff[23:8] - {15'd0, u16_dn};
      end else begin
         if (mag2_ff[23:8] >= 16'd32767) u16_r = 16'hffff;
         else u16_r = 16'd32768 + mag2_ff[23:8] + {15'd0, u16_up};
      end
      // integer to float
      av = iv2_ff[31] ? (32'd0 - iv2_ff) : iv2_ff;
      lz = 5'd0;
      for (int i = 0; i < 25; i++) if (av[i]) lz = i[4:0];
      nrm = av << (5'd23 - lz);
      case (c2_ff.sf)
         FMT_S24: ex_base = 8'd104;
         FMT_S16, FMT_U16: ex_base = 8'd112;
         default: ex_base = 8'd120;
      endcase
      if (av == 32'd0) flt_r = 32'd0;
      else flt_r = {iv2_ff[31], ex_base + {3'd0, lz}, nrm[22:0]};
      res3_in = 32'd0;
      if (c2_ff.sf == FMT_F32) begin
         case (c2_ff.df)
            FMT_S24: res3_in = {8'd0, s24_r};
            FMT_S16: res3_in = {16'd0, s16_r};
            FMT_U16: res3_in = {16'd0, u16_r};
            FMT_S8:  res3_in = {24'd0, s16_r[15:8]};
            default: res3_in = {24'd0, u16_r[15:8]};
         endcase
      end else if (c2_ff.df == FMT_F32) res3_in = flt_r;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         c3_ff   <= c2_ff;
         res3_ff <= res3_in;
         n3_ff   <= n2_ff;
      end
   end

   // carry raw sample for integer to integer paths
   always_ff @(posedge clock) begin
      if (en2) n2_ff <= n1_ff;
   end

   // stage 4: integer remap and pack
   logic [31:0] r4;
   logic [31:0] out_in, out_ff;
   logic        uns_ff;

   always_comb begin
      r4 = res3_ff;
      if (c3_ff.sf != FMT_F32 && c3_ff.df != FMT_F32) begin
         case (c3_ff.sf)
            FMT_S24: r4 = (c3_ff.df == FMT_S16) ? (n3_ff >> 8) : n3_ff;
            FMT_S16: begin
               case (c3_ff.df)
                  FMT_S24: r4 = n3_ff << 8;
                  FMT_S8:  r4 = n3_ff >> 8;
                  FMT_U8:  r4 = (n3_ff >> 8) ^ 32'h80;
                  FMT_U16: r4 = n3_ff ^ 32'h8000;
                  default: r4 = n3_ff;
               endcase
            end
            FMT_U16: begin
               case (c3_ff.df)
                  FMT_S8:  r4 = (n3_ff >> 8) ^ 32'h80;
                  FMT_U8:  r4 = n3_ff >> 8;
                  FMT_S16: r4 = n3_ff ^ 32'h8000;
                  default: r4 = n3_ff;
               endcase
            end
            FMT_S8: begin
               case (c3_ff.df)
                  FMT_S16: r4 = n3_ff << 8;
                  FMT_U16: r4 = (n3_ff ^ 32'h80) << 8;
                  default: r4 = n3_ff ^ 32'h80;
               endcase
            end
            default: begin
               case (c3_ff.df)
                  FMT_S16: r4 = (n3_ff ^ 32'h80) << 8;
                  FMT_U16: r4 = n3_ff << 8;
                  default: r4 = n3_ff ^ 32'h80;
               endcase
            end
         endcase
      end
      case (c3_ff.df)
         FMT_S8, FMT_U8: out_in = {24'd0, r4[7:0]};
         FMT_S24: out_in = c3_ff.ds ? {8'd0, r4[7:0], r4[15:8], r4[23:16]}
                                    : {8'd0, r4[23:0]};
         FMT_F32: out_in = r4;
         default: out_in = c3_ff.ds ? {16'd0, r4[7:0], r4[15:8]} : {16'd0, r4[15:0]};
      endcase
      if (c3_ff.bad) out_in = 32'd0;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         out_ff <= out_in;
         uns_ff <= c3_ff.bad;
      end
   end

   assign rsp_valid       = v4_ff;
   assign rsp_sample_out  = out_ff;
   assign rsp_unsupported = uns_ff;

endmodule

[tb/pcm_sample_format_converter_tb.sv]
// testbench for the pcm sample format converter: directed, all format pairs and random beats
`timescale 1ns / 100ps
module pcm_sample_format_converter_tb;
   import psfc_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_sample_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_sample_out;
   logic        rsp_unsupported;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic [2:0]  cur_src_fmt = FMT_F32;
   logic        cur_src_swap = 1'b0;
   logic [2:0]  cur_dst_fmt = FMT_S16;
   logic        cur_dst_swap = 1'b0;

   logic [31:0] want_sample[$];
   logic        want_unsup[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          hold = 0;
   bit          quiet = 1'b0;

   pcm_sample_format_converter dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // float arithmetic helpers
   function automatic real f32_value(logic [31:0] b);
      int  e;
      real m;
      e = b[30:23];
      if (e == 255) return (b[22:0] != 0) ? 0.0 : (b[31] ? -2.0 : 2.0);
      if (e == 0) m = real'(b[22:0]) * 2.0 ** (-149);
      else m = real'(32'd8388608 + b[22:0]) * 2.0 ** (e - 150);
      return b[31] ? -m : m;
   endfunction

   function automatic int expo(real a);
      int e;
      e = 0;
      while (a >= 2.0) begin
         a = a / 2.0;
         e++;
      end
      while (a < 1.0) begin
         a = a * 2.0;
         e--;
      end
      return e;
   endfunction

   function automatic real round_even(real x);
      real fl, d;
      fl = $floor(x);
      d = x - fl;
      if (d > 0.5 || (d == 0.5 && $floor(fl / 2.0) * 2.0 != fl)) fl = fl + 1.0;
      return fl;
   endfunction

   function automatic real round_f32(real x);
      real q;
      if (x == 0.0) return 0.0;
      q = 2.0 ** (expo(x < 0.0 ? -x : x) - 23);
      return round_even(x / q) * q;
   endfunction

   function automatic logic [31:0] f32_bits(real x);
      real a;
      int  e, mant;
      if (x == 0.0) return '0;
      a = x < 0.0 ? -x : x;
      e = expo(a);
      mant = $rtoi((a / 2.0 ** e - 1.0) * 8388608.0);
      return {x < 0.0, 8'(e + 127), 23'(mant)};
   endfunction

   function automatic logic [31:0] float_to_s16(real f);
      real s;
      s = round_f32(f + 384.0);
      if (s < 0.0) return 32'h8000;
      if (s > 384.0 + 32767.0 / 32768.0) return 32'h7fff;
      if (s < 383.0) return 32'h8000;
      return 32'(16'($rtoi((s - 384.0) * 32768.0)));
   endfunction

   function automatic logic [31:0] float_to_u16(real f);
      real s;
      if (f >= 1.0) return 32'd65535;
      if (f < -1.0) return 32'd0;
      s = round_f32(32768.0 + round_f32(f * 32768.0));
      if (s >= 65535.0) return 32'd65535;
      if (s <= 0.0) return 32'd0;
      return 32'($rtoi(s));
   endfunction

   function automatic logic [31:0] float_to_s24(real f);
      if (f >= 1.0) return 32'h7fffff;
      if (f < -1.0) return 32'h800000;
      return 32'(24'($rtoi(f * 8388608.0)));
   endfunction

   function automatic logic [31:0] swap16(logic [31:0] v);
      return {16'h0, v[7:0], v[15:8]};
   endfunction

   function automatic logic [31:0] swap24(logic [31:0] v);
      return {8'h0, v[7:0], v[15:8], v[23:16]};
   endfunction

   function automatic bit pair_supported(logic [2:0] sf, logic ss, logic [2:0] df, logic ds);
      case (sf)
         FMT_F32: return df <= FMT_S24;
         FMT_S24: return df == FMT_F32 || df == FMT_S16 || (df == FMT_S24 && ss != ds);
         FMT_S16: return df == FMT_F32 || df == FMT_S24 || df == FMT_S8 || df == FMT_U8 ||
                         (df == FMT_S16 && ss != ds) || (df == FMT_U16 && !ds);
         FMT_U16: return df == FMT_F32 || df == FMT_S8 || df == FMT_U8 ||
                         (df == FMT_U16 && ss != ds) || (df == FMT_S16 && !ds);
         FMT_S8:  return df == FMT_F32 || df == FMT_S16 || df == FMT_U16 || df == FMT_U8;
         FMT_U8:  return df == FMT_F32 || df == FMT_S16 || df == FMT_U16 || df == FMT_S8;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [31:0] reencode(logic [2:0] sf, logic [31:0] n, logic [2:0] df);
      real f;
      if (sf == FMT_F32) begin
         f = f32_value(n);
         case (df)
            FMT_S24: return float_to_s24(f);
            FMT_S16: return float_to_s16(f);
            FMT_U16: return float_to_u16(f);
            FMT_S8:  return float_to_s16(f) >> 8;
            default: return float_to_u16(f) >> 8;
         endcase
      end
      if (df == FMT_F32) begin
         case (sf)
            FMT_S24: return f32_bits(real'($signed(n[23:0])) / 8388608.0);
            FMT_S16: return f32_bits(real'($signed(n[15:0])) / 32768.0);
            FMT_U16: return f32_bits(real'(int'(n) - 32768) / 32768.0);
            FMT_S8:  return f32_bits(real'($signed(n[7:0])) / 128.0);
            default: return f32_bits(real'(int'(n) - 128) / 128.0);
         endcase
      end
      case (sf)
         FMT_S24: return df == FMT_S16 ? n >> 8 : n;
         FMT_S16: begin
            if (df == FMT_S24) return n << 8;
            if (df == FMT_S8) return n >> 8;
            if (df == FMT_U8) return (n >> 8) ^ 32'h80;
            if (df == FMT_U16) return n ^ 32'h8000;
            return n;
         end
         FMT_U16: begin
            if (df == FMT_S8) return (n >> 8) ^ 32'h80;
            if (df == FMT_U8) return n >> 8;
            if (df == FMT_S16) return n ^ 32'h8000;
            return n;
         end
         FMT_S8: begin
            if (df == FMT_S16) return n << 8;
            if (df == FMT_U16) return (n ^ 32'h80) << 8;
            return n ^ 32'h80;
         end
         default: begin
            if (df == FMT_S16) return (n ^ 32'h80) << 8;
            if (df == FMT_U16) return n << 8;
            return n ^ 32'h80;
         end
      endcase
   endfunction

   task automatic predict_sample(input logic [31:0] raw);
      logic [2:0]  sf, df;
      logic        ss, ds;
      logic [31:0] n, r;
      sf = cur_src_fmt;
      df = cur_dst_fmt;
      ss = (sf >= FMT_S16 && sf <= FMT_S24) ? cur_src_swap : 1'b0;
      ds = (df >= FMT_S16 && df <= FMT_S24) ? cur_dst_swap : 1'b0;
      if (!pair_supported(sf, ss, df, ds)) begin
         want_sample.push_back('0);
         want_unsup.push_back(1'b1);
         return;
      end
      if (sf == FMT_S8 || sf == FMT_U8) n = raw & 32'hff;
      else if (sf == FMT_S24) n = ss ? swap24(raw) : raw & 32'hffffff;
      else if (sf == FMT_F32) n = raw;
      else n = ss ? swap16(raw) : raw & 32'hffff;
      r = reencode(sf, n, df);
      if (df == FMT_S8 || df == FMT_U8) r = r & 32'hff;
      else if (df == FMT_S24) r = ds ? swap24(r) : r & 32'hffffff;
      else if (df != FMT_F32) r = ds ? swap16(r) : r & 32'hffff;
      want_sample.push_back(r);
      want_unsup.push_back(1'b0);
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // result side: check each beat, draw a stall after it
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (want_sample.size() == 0) begin
               report("unexpected beat", rsp_sample_out, '0);
            end else begin
               if (rsp_sample_out !== want_sample[0])
                  report("sample_out", rsp_sample_out, want_sample[0]);
               if (rsp_unsupported !== want_unsup[0])
                  report("unsupported", 32'(rsp_unsupported), 32'(want_unsup[0]));
               void'(want_sample.pop_front());
               void'(want_unsup.pop_front());
            end
            hold = quiet ? 0 : $urandom_range(0, 3);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_sample(input logic [31:0] raw);
      int  gap;
      bit  st;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= raw;
      forever begin
         @(negedge clock);
         st = req_stall;
         @(posedge clock);
         if (!st) break;
      end
      predict_sample(raw);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (want_sample.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input int val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_SRC_FMT:  cur_src_fmt = 3'(val);
         REG_SRC_SWAP: cur_src_swap = 1'(val);
         REG_DST_FMT:  cur_dst_fmt = 3'(val);
         default:      cur_dst_swap = 1'(val);
      endcase
   endtask

   task automatic set_formats(input int sf, input int ss, input int df, input int ds);
      wait_drained();
      csr_write(REG_SRC_FMT, sf);
      csr_write(REG_SRC_SWAP, ss);
      csr_write(REG_DST_FMT, df);
      csr_write(REG_DST_SWAP, ds);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample(logic [2:0] sf);
      int k;
      k = $urandom_range(0, 9);
      if (sf == FMT_F32 && k < 6)
         return {1'($urandom), 8'($urandom_range(100, 127)), 23'($urandom)};
      if (sf == FMT_F32 && k == 6)
         return {1'($urandom), 8'($urandom_range(0, 1) ? 8'hff : 8'h00), 23'($urandom)};
      if (k == 7)
         return {$urandom_range(0, 1) ? 32'h0 : 32'hffffffff} ^ (32'h1 << $urandom_range(0, 31));
      return $urandom;
   endfunction

   task automatic test_directed();
      logic [31:0] floats[13] = '{32'h3f800000, 32'hbf800000, 32'h7fc00000, 32'h7f800000,
         32'hff800000, 32'h3f7fffff, 32'hbf7fffff, 32'h38000000, 32'h37800000,
         32'h38400000, 32'h80000000, 32'h00000001, 32'h477fffff};
      foreach (floats[i]) send_sample(floats[i]);
      set_formats(FMT_F32, 0, FMT_U16, 1);
      send_sample(32'hbf800000);
      send_sample(32'hb7800000);
      send_sample(32'h3f7fffff);
      set_formats(FMT_F32, 0, FMT_S24, 1);
      send_sample(32'hbf800001);
      send_sample(32'h3f7fffff);
      set_formats(FMT_S24, 1, FMT_F32, 0);
      send_sample(32'hff000080);
      send_sample(32'h00ffff7f);
      set_formats(FMT_U8, 0, FMT_S8, 0);
      send_sample(32'hffffff00);
      send_sample(32'h000000ff);
      set_formats(FMT_S16, 0, FMT_S16, 0);
      send_sample(32'h00001234);
   endtask

   task automatic test_all_pairs();
      for (int sf = 0; sf < 8; sf++)
         for (int df = 0; df < 8; df++)
            for (int sw = 0; sw < 4; sw++) begin
               set_formats(sf, sw >> 1, df, sw & 1);
               send_sample(pick_sample(3'(sf)));
            end
   endtask

   task automatic test_random();
      int sf, ss, df, ds;
      for (int ph = 0; ph < 22; ph++) begin
         do begin
            sf = $urandom_range(0, 5);
            ss = $urandom_range(0, 1);
            df = $urandom_range(0, 5);
            ds = $urandom_range(0, 1);
         end while (!pair_supported(3'(sf), 1'(ss), 3'(df), 1'(ds)) &&
                    $urandom_range(0, 5) != 0);
         set_formats(sf, ss, df, ds);
         quiet = (ph % 7 == 3);
         for (int i = 0; i < 50; i++) begin
            if (ph == 5 && i == 25) wait_drained();
            send_sample(pick_sample(3'(sf)));
         end
         quiet = 1'b0;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_all_pairs();
      test_random();
      wait_drained();
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

[pcm_sample_format_converter.f]
sv/psfc_pkg.sv
sv/pcm_sample_format_converter.sv
tb/pcm_sample_format_converter_tb.sv
